FILE: hw/rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Constants, widths, state type and arctangent table shared by the
// waypoint-to-drive-command block and its CORDIC unit.
// ----------------------------------------------------------------------------
package wdt_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;

	// length path: guard bits, vector width, multiplier operands
	localparam int LEN_G   = (COORD_WIDTH <= 28) ? 8 : 4;
	localparam int D_W     = COORD_WIDTH + 1;
	localparam int LEN_W   = COORD_WIDTH + LEN_G + 4;

	// angle path: vectors are cut down to at most 24 significant bits
	localparam int ANG_E   = (COORD_WIDTH > 24) ? 24 : COORD_WIDTH;
	localparam int DROP    = (COORD_WIDTH > 24) ? (COORD_WIDTH - 24) : 0;
	localparam int SC_SH   = 59 - 2 * ANG_E;
	localparam int V_W     = D_W - DROP;
	localparam int PR_W    = 2 * V_W + 1;

	// shared multiplier
	localparam int MA_W    = (LEN_W > V_W) ? LEN_W : V_W;
	localparam int MB_W    = (V_W > 25) ? V_W : 25;
	localparam int PM_W    = MA_W + MB_W;

	localparam int CORD_W  = 64;
	localparam int Z_W     = 26;
	localparam int TR_W    = Z_W + 2;
	localparam int STEP_W  = $clog2(CORDIC_STEPS);

	localparam int LEN_OUT_W = 17;
	localparam int TURN_W    = 16;

	localparam logic [LEN_OUT_W-1:0] LEN_MAX   = 17'd131071;
	localparam logic [23:0]          INVK_Q24  = 24'd10187998;
	localparam int                   TURN_MAX  = 23040;
	localparam logic signed [Z_W-1:0] DEG180_Q16 = Z_W'(180 * 65536);
	localparam logic signed [Z_W-1:0] DEG90_Q16  = Z_W'(90 * 65536);
	localparam logic signed [PM_W-1:0] LEN_HALF  = PM_W'(1) <<< (23 + LEN_G);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_LEN_RUN,
		S_LEN_MUL,
		S_LEN_RND,
		S_PROD,
		S_ANG_SETUP,
		S_ANG_RUN,
		S_TURN_RND,
		S_EMIT
	} wdt_state_t;

	// atan(2^-s) in degrees, Q16
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] s);
		logic signed [Z_W-1:0] a;
		case (s)
			5'd0:    a = Z_W'(2949120);
			5'd1:    a = Z_W'(1740967);
			5'd2:    a = Z_W'(919879);
			5'd3:    a = Z_W'(466945);
			5'd4:    a = Z_W'(234379);
			5'd5:    a = Z_W'(117304);
			5'd6:    a = Z_W'(58666);
			5'd7:    a = Z_W'(29335);
			5'd8:    a = Z_W'(14668);
			5'd9:    a = Z_W'(7334);
			5'd10:   a = Z_W'(3667);
			5'd11:   a = Z_W'(1833);
			5'd12:   a = Z_W'(917);
			5'd13:   a = Z_W'(458);
			5'd14:   a = Z_W'(229);
			5'd15:   a = Z_W'(115);
			5'd16:   a = Z_W'(57);
			5'd17:   a = Z_W'(29);
			5'd18:   a = Z_W'(14);
			5'd19:   a = Z_W'(7);
			5'd20:   a = Z_W'(4);
			5'd21:   a = Z_W'(2);
			5'd22:   a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: hw/rtl/waypoints_to_drive_turns_top.sv
// ----------------------------------------------------------------------------
// waypoints_to_drive_turns_top
// Turns a stream of path waypoints into drive-length / turn-angle commands.
// ----------------------------------------------------------------------------
// One waypoint request is taken at a time. A point that only fills the
// two-point history goes from idle to start and back. A point that produces
// a turn command takes one CORDIC run for the segment length, a multiply and
// round, four products for cross and dot, and a second CORDIC run for the
// angle, all on one shared CORDIC unit and one shared multiplier. When cross
// or dot is zero the angle run is skipped. The closing command of a path
// adds a further CORDIC run for its length. A finished command sits in
// the output register, so the next waypoint can be taken while it waits to
// be read; a command that cannot enter the register stalls the sequencer.
module waypoints_to_drive_turns_top import wdt_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [COORD_WIDTH-1:0] waypoint_x,
	input  logic signed [COORD_WIDTH-1:0] waypoint_y,
	input  logic                        last_point,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [LEN_OUT_W-1:0]        segment_length,
	output logic signed [TURN_W-1:0]    turn_angle,
	output logic                        end_of_path
);

	wdt_state_t state_q, state_d;

	logic signed [COORD_WIDTH-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [1:0]                    held_q;
	logic signed [COORD_WIDTH-1:0] px_q, py_q;
	logic                          last_q;
	logic                          close_q;
	logic [2:0]                    pcnt_q;
	logic signed [PR_W-1:0]        cr_q, dt_q;
	logic signed [Z_W-1:0]         ang_z_q;
	logic [LEN_OUT_W-1:0]          len_q;
	logic signed [TURN_W-1:0]      turn_q;
	logic signed [PM_W-1:0]        prod_s1;

	logic                          out_valid_q;
	logic [LEN_OUT_W-1:0]          out_len_q;
	logic signed [TURN_W-1:0]      out_turn_q;
	logic                          out_end_q;

	// control decoded by the sequencer
	logic cord_start, commit, emit_load;

	// CORDIC unit
	logic signed [CORD_W-1:0] cord_x0, cord_y0, cord_x;
	logic signed [Z_W-1:0]    cord_z0, cord_z;
	logic                     cord_done;

	// length operands
	logic                     len_close;
	logic signed [D_W-1:0]    len_dx, len_dy, len_ax;
	logic signed [CORD_W-1:0] len_x0, len_y0;

	// angle operands
	logic signed [D_W-1:0]    d1x, d1y, d2x, d2y;
	logic signed [V_W-1:0]    v1x, v1y, v2x, v2y;
	logic signed [CORD_W-1:0] ang_sx, ang_sy, ang_x0, ang_y0;
	logic signed [Z_W-1:0]    ang_z0;
	logic                     cr_zero, dt_zero, dt_neg;

	// multiplier and rounding
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PM_W-1:0]   len_sum, len_shr;
	logic [LEN_OUT_W-1:0]     len_rnd;
	logic signed [TR_W-1:0]   turn_t, turn_r;
	logic signed [TURN_W-1:0] turn_rnd;

	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	// ---------------- operand selection ----------------
	always_comb begin
		len_close = (state_q == S_EMIT) || (held_q < 2'd2);
		if (len_close) begin
			len_dx = {px_q[COORD_WIDTH-1], px_q} - {newer_x_q[COORD_WIDTH-1], newer_x_q};
			len_dy = {py_q[COORD_WIDTH-1], py_q} - {newer_y_q[COORD_WIDTH-1], newer_y_q};
		end else begin
			len_dx = {newer_x_q[COORD_WIDTH-1], newer_x_q} - {older_x_q[COORD_WIDTH-1], older_x_q};
			len_dy = {newer_y_q[COORD_WIDTH-1], newer_y_q} - {older_y_q[COORD_WIDTH-1], older_y_q};
		end
		len_ax = len_dx[D_W-1] ? -len_dx : len_dx;
		len_x0 = CORD_W'(len_ax) <<< LEN_G;
		len_y0 = CORD_W'(len_dy) <<< LEN_G;

		d1x = {older_x_q[COORD_WIDTH-1], older_x_q} - {newer_x_q[COORD_WIDTH-1], newer_x_q};
		d1y = {older_y_q[COORD_WIDTH-1], older_y_q} - {newer_y_q[COORD_WIDTH-1], newer_y_q};
		d2x = {px_q[COORD_WIDTH-1], px_q} - {newer_x_q[COORD_WIDTH-1], newer_x_q};
		d2y = {py_q[COORD_WIDTH-1], py_q} - {newer_y_q[COORD_WIDTH-1], newer_y_q};
		v1x = V_W'(d1x >>> DROP);
		v1y = V_W'(d1y >>> DROP);
		v2x = V_W'(d2x >>> DROP);
		v2y = V_W'(d2y >>> DROP);

		cr_zero = (cr_q == '0);
		dt_zero = (dt_q == '0);
		dt_neg  = dt_q[PR_W-1];
		ang_sx  = CORD_W'(dt_q) <<< SC_SH;
		ang_sy  = CORD_W'(cr_q) <<< SC_SH;
		// left half-plane: pre-rotate by 180 degrees
		if (dt_neg) begin
			ang_x0 = -ang_sx;
			ang_y0 = -ang_sy;
			ang_z0 = cr_q[PR_W-1] ? -DEG180_Q16 : DEG180_Q16;
		end else begin
			ang_x0 = ang_sx;
			ang_y0 = ang_sy;
			ang_z0 = '0;
		end

		if (state_q == S_ANG_SETUP) begin
			cord_x0 = ang_x0;
			cord_y0 = ang_y0;
			cord_z0 = ang_z0;
		end else begin
			cord_x0 = len_x0;
			cord_y0 = len_y0;
			cord_z0 = '0;
		end

		if (state_q == S_LEN_MUL) begin
			mul_a = MA_W'(cord_x);
			mul_b = MB_W'(INVK_Q24);
		end else begin
			case (pcnt_q)
				3'd0:    begin mul_a = MA_W'(v1x); mul_b = MB_W'(v2y); end
				3'd1:    begin mul_a = MA_W'(v1y); mul_b = MB_W'(v2x); end
				3'd2:    begin mul_a = MA_W'(v1x); mul_b = MB_W'(v2x); end
				default: begin mul_a = MA_W'(v1y); mul_b = MB_W'(v2y); end
			endcase
		end

		// length: round half up, saturate
		len_sum = prod_s1 + LEN_HALF;
		len_shr = len_sum >>> (24 + LEN_G);
		len_rnd = (len_shr > PM_W'(LEN_MAX)) ? LEN_MAX : LEN_OUT_W'(len_shr);

		// turn: negate, round to Q7, clamp
		turn_t = -TR_W'(ang_z_q);
		turn_r = (turn_t + TR_W'(256)) >>> 9;
		if (turn_r > TR_W'(TURN_MAX))
			turn_rnd = TURN_W'(TURN_MAX);
		else if (turn_r < -TR_W'(TURN_MAX))
			turn_rnd = -TURN_W'(TURN_MAX);
		else
			turn_rnd = TURN_W'(turn_r);
	end

	wdt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_init (cord_x0),
		.y_init (cord_y0),
		.z_init (cord_z0),
		.done   (cord_done),
		.x_res  (cord_x),
		.z_res  (cord_z)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cord_start = 1'b0;
		commit     = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = S_START;
			end
			S_START: begin
				if (held_q >= 2'd2 || (last_q && held_q != 2'd0)) begin
					cord_start = 1'b1;
					state_d    = S_LEN_RUN;
				end else if (last_q) begin
					state_d = S_EMIT;
				end else begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_LEN_RUN: begin
				if (cord_done)
					state_d = S_LEN_MUL;
			end
			S_LEN_MUL: state_d = S_LEN_RND;
			S_LEN_RND: state_d = close_q ? S_EMIT : S_PROD;
			S_PROD: begin
				if (pcnt_q == 3'd4)
					state_d = S_ANG_SETUP;
			end
			S_ANG_SETUP: begin
				if (cr_zero || dt_zero) begin
					state_d = S_TURN_RND;
				end else begin
					cord_start = 1'b1;
					state_d    = S_ANG_RUN;
				end
			end
			S_ANG_RUN: begin
				if (cord_done)
					state_d = S_TURN_RND;
			end
			S_TURN_RND: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					emit_load = 1'b1;
					if (!close_q && last_q) begin
						// closing segment follows the turn command
						cord_start = 1'b1;
						state_d    = S_LEN_RUN;
					end else begin
						commit  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- point history ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q <= '0;
			older_y_q <= '0;
			newer_x_q <= '0;
			newer_y_q <= '0;
			held_q    <= '0;
		end else if (commit) begin
			if (last_q) begin
				older_x_q <= '0;
				older_y_q <= '0;
				newer_x_q <= '0;
				newer_y_q <= '0;
				held_q    <= '0;
			end else begin
				older_x_q <= newer_x_q;
				older_y_q <= newer_y_q;
				newer_x_q <= px_q;
				newer_y_q <= py_q;
				if (held_q < 2'd2)
					held_q <= held_q + 2'd1;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= 1'b0;
			pcnt_q  <= '0;
		end else begin
			if (state_q == S_START)
				close_q <= (held_q < 2'd2);
			else if (emit_load && !close_q && last_q)
				close_q <= 1'b1;
			if (state_q == S_PROD)
				pcnt_q <= pcnt_q + 3'd1;
			else
				pcnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (state_q == S_IDLE && in_valid) begin
			px_q   <= waypoint_x;
			py_q   <= waypoint_y;
			last_q <= last_point;
		end
		if (state_q == S_START)
			len_q <= '0;
		else if (state_q == S_LEN_RND)
			len_q <= len_rnd;
		if (state_q == S_PROD) begin
			case (pcnt_q)
				3'd1:    cr_q <= PR_W'(prod_s1);
				3'd2:    cr_q <= cr_q - PR_W'(prod_s1);
				3'd3:    dt_q <= PR_W'(prod_s1);
				3'd4:    dt_q <= dt_q + PR_W'(prod_s1);
				default: ;
			endcase
		end
		if (state_q == S_ANG_SETUP) begin
			if (cr_zero)
				ang_z_q <= dt_neg ? DEG180_Q16 : '0;
			else if (dt_zero)
				ang_z_q <= cr_q[PR_W-1] ? -DEG90_Q16 : DEG90_Q16;
		end else if (state_q == S_ANG_RUN && cord_done) begin
			ang_z_q <= cord_z;
		end
		if (state_q == S_TURN_RND)
			turn_q <= turn_rnd;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_len_q  <= len_q;
			out_turn_q <= close_q ? '0 : turn_q;
			out_end_q  <= close_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign segment_length = out_len_q;
	assign turn_angle     = out_turn_q;
	assign end_of_path    = out_end_q;

endmodule

FILE: hw/rtl/wdt_cordic.sv
// ----------------------------------------------------------------------------
// wdt_cordic
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, drives y
// toward zero and accumulates the rotation angle in degrees Q16.
// ----------------------------------------------------------------------------
module wdt_cordic import wdt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [CORD_W-1:0] x_init,
	input  logic signed [CORD_W-1:0] y_init,
	input  logic signed [Z_W-1:0]    z_init,
	output logic                     done,
	output logic signed [CORD_W-1:0] x_res,
	output logic signed [Z_W-1:0]    z_res
);

	logic                     busy_q;
	logic                     done_q;
	logic [STEP_W-1:0]        cnt_q;
	logic signed [CORD_W-1:0] x_q;
	logic signed [CORD_W-1:0] y_q;
	logic signed [Z_W-1:0]    z_q;

	logic [4:0]               shamt;
	logic signed [CORD_W-1:0] xs;
	logic signed [CORD_W-1:0] ys;
	logic signed [Z_W-1:0]    ang;
	logic                     last_step;

	always_comb begin
		shamt     = 5'(cnt_q);
		xs        = x_q >>> shamt;
		ys        = y_q >>> shamt;
		ang       = atan_q16(shamt);
		last_step = (cnt_q == STEP_W'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (busy_q) begin
			if (!y_q[CORD_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

	assign done  = done_q;
	assign x_res = x_q;
	assign z_res = z_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for waypoints_to_drive_turns_top. Paths of waypoint
// requests go in and drive commands come out. A bit-exact predictor computes
// the CORDIC segment length and turn angle of each command, and a monitor
// checks every command against the oldest prediction. The bench runs under
// three traffic profiles and, at each profile change and at some path starts,
// pauses the sender until outstanding commands have drained.
// ----------------------------------------------------------------------------
module tb import wdt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     GUARD         = (COORD_WIDTH <= 28) ? 8 : 4;
	localparam int     ANG_BITS      = (COORD_WIDTH > 24) ? 24 : COORD_WIDTH;
	localparam int     TRIM          = (COORD_WIDTH > 24) ? (COORD_WIDTH - 24) : 0;
	localparam int     PROD_SHIFT    = 59 - 2 * ANG_BITS;
	localparam longint INV_GAIN_Q24  = 64'd10187998;
	localparam longint LEN_SAT       = 131071;
	localparam longint TURN_LIMIT    = 23040;
	localparam longint HALF_TURN     = 180 * 65536;
	localparam longint QUARTER_TURN  = 90 * 65536;
	localparam int     QUIET_LIMIT   = 20000;
	localparam int     SETTLE_CYCLES = 200;

	typedef enum logic [1:0] {
		PACE_SLOW_SINK,
		PACE_SLOW_SOURCE,
		PACE_FREE
	} pace_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} coord_t;

	typedef struct packed {
		coord_t at;
		logic   last;
		logic   hold;
		pace_t  pace;
	} waypoint_req_t;

	typedef struct packed {
		logic [LEN_OUT_W-1:0]     len;
		logic signed [TURN_W-1:0] turn;
		logic                     eop;
	} drive_cmd_t;

	typedef struct packed {
		longint mag;
		longint ang;
	} vec_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_WIDTH-1:0] waypoint_x = '0;
	logic signed [COORD_WIDTH-1:0] waypoint_y = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [LEN_OUT_W-1:0] segment_length;
	logic signed [TURN_W-1:0] turn_angle;
	logic end_of_path;

	waypoint_req_t wp_q[$];
	drive_cmd_t    cmd_due_q[$];
	int            wp_total = 0;
	int            cmds_due;
	int            cmds_seen;
	int            errs = 0;
	int            quiet;
	pace_t         pace = PACE_SLOW_SINK;

	// predictor copy of the path history
	longint older_x = 0, older_y = 0, newer_x = 0, newer_y = 0;
	int     held = 0;

	waypoint_req_t next_req;
	drive_cmd_t    want;
	coord_t        at;
	int            path_len, pick, k;

	waypoints_to_drive_turns_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.waypoint_x     (waypoint_x),
		.waypoint_y     (waypoint_y),
		.last_point     (last_point),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_length (segment_length),
		.turn_angle     (turn_angle),
		.end_of_path    (end_of_path)
	);

	always #5 clk = ~clk;

	// atan(2^-s) in degrees, Q16
	function automatic longint arctan_step(int s);
		case (s)
			0:       return 2949120;
			1:       return 1740967;
			2:       return 919879;
			3:       return 466945;
			4:       return 234379;
			5:       return 117304;
			6:       return 58666;
			7:       return 29335;
			8:       return 14668;
			9:       return 7334;
			10:      return 3667;
			11:      return 1833;
			12:      return 917;
			13:      return 458;
			14:      return 229;
			15:      return 115;
			16:      return 57;
			17:      return 29;
			18:      return 14;
			19:      return 7;
			20:      return 4;
			21:      return 2;
			22:      return 1;
			default: return 0;
		endcase
	endfunction

	function automatic vec_out_t cordic_vector(longint vx, longint vy);
		vec_out_t r;
		longint   xs, ys;
		int       i;
		r.ang = 0;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = vx >>> (i & 31);
			ys = vy >>> (i & 31);
			if (vy >= 0) begin
				vx += ys;
				vy -= xs;
				r.ang += arctan_step(i & 31);
			end else begin
				vx -= ys;
				vy += xs;
				r.ang -= arctan_step(i & 31);
			end
		end
		r.mag = vx;
		return r;
	endfunction

	function automatic logic [LEN_OUT_W-1:0] seg_length(longint dx, longint dy);
		vec_out_t r;
		longint   p;
		if (dx < 0)
			dx = -dx;
		dx = dx <<< GUARD;
		dy = dy <<< GUARD;
		if (dx == 0 && dy == 0)
			return '0;
		r = cordic_vector(dx, dy);
		// undo CORDIC gain, round half up
		p = (r.mag * INV_GAIN_Q24 + (longint'(1) <<< (23 + GUARD))) >>> (24 + GUARD);
		return (p > LEN_SAT) ? LEN_OUT_W'(LEN_SAT) : LEN_OUT_W'(p);
	endfunction

	function automatic logic signed [TURN_W-1:0] turn_at(input longint ax, ay, bx, by,
		px, py);
		longint   v1x, v1y, v2x, v2y, cr, dt, z, q, sx, sy;
		vec_out_t r;
		v1x = (ax - bx) >>> TRIM;
		v1y = (ay - by) >>> TRIM;
		v2x = (px - bx) >>> TRIM;
		v2y = (py - by) >>> TRIM;
		cr = v1x * v2y - v1y * v2x;
		dt = v1x * v2x + v1y * v2y;
		if (cr == 0)
			z = (dt < 0) ? HALF_TURN : 0;
		else if (dt == 0)
			z = (cr > 0) ? QUARTER_TURN : -QUARTER_TURN;
		else begin
			sx = dt <<< PROD_SHIFT;
			sy = cr <<< PROD_SHIFT;
			z = 0;
			// fold the left half-plane onto the right before vectoring
			if (sx < 0) begin
				z = (sy >= 0) ? HALF_TURN : -HALF_TURN;
				sx = -sx;
				sy = -sy;
			end
			r = cordic_vector(sx, sy);
			z += r.ang;
		end
		q = (256 - z) >>> 9;
		if (q > TURN_LIMIT)
			q = TURN_LIMIT;
		if (q < -TURN_LIMIT)
			q = -TURN_LIMIT;
		return TURN_W'(q);
	endfunction

	// queues the commands one waypoint causes, returns how many
	function automatic int predict_point(input logic signed [COORD_WIDTH-1:0] wx, wy,
		input logic last);
		drive_cmd_t c;
		longint     px, py;
		int         n;
		px = wx;
		py = wy;
		n = 0;
		if (held >= 2) begin
			c.len = seg_length(newer_x - older_x, newer_y - older_y);
			c.turn = turn_at(older_x, older_y, newer_x, newer_y, px, py);
			c.eop = 1'b0;
			cmd_due_q.insert(cmd_due_q.size(), c);
			n++;
		end
		if (last) begin
			c.len = (held == 0) ? '0 : seg_length(px - newer_x, py - newer_y);
			c.turn = '0;
			c.eop = 1'b1;
			cmd_due_q.insert(cmd_due_q.size(), c);
			older_x = 0;
			older_y = 0;
			newer_x = 0;
			newer_y = 0;
			held = 0;
			return n + 1;
		end
		older_x = newer_x;
		older_y = newer_y;
		newer_x = px;
		newer_y = py;
		if (held < 2)
			held++;
		return n;
	endfunction

	task automatic add_wp(input int x, input int y, input bit last, input bit hold);
		waypoint_req_t r;
		r.at.x = COORD_WIDTH'(x);
		r.at.y = COORD_WIDTH'(y);
		r.last = last;
		r.pace = (wp_total < 575) ? PACE_SLOW_SINK :
			(wp_total < 1150) ? PACE_SLOW_SOURCE : PACE_FREE;
		// drain outstanding commands whenever the traffic profile changes
		r.hold = hold || (wp_total > 0 && r.pace != wp_q[$].pace);
		wp_q.insert(wp_q.size(), r);
		wp_total++;
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] extreme_coord();
		case ($urandom_range(3))
			0:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
			1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	function automatic coord_t next_coord(coord_t from);
		coord_t c;
		int     sel;
		sel = $urandom_range(99);
		c = from;
		if (sel < 35) begin
			c.x = COORD_WIDTH'($urandom);
			c.y = COORD_WIDTH'($urandom);
		end else if (sel < 65) begin
			c.x = from.x + COORD_WIDTH'($urandom_range(128)) - COORD_WIDTH'(64);
			c.y = from.y + COORD_WIDTH'($urandom_range(128)) - COORD_WIDTH'(64);
		end else if (sel < 75) begin
			// repeated point
		end else if (sel < 88) begin
			// axis-aligned move: collinear and right-angle turns
			if ($urandom_range(1) == 1)
				c.x = from.x + COORD_WIDTH'($urandom);
			else
				c.y = from.y + COORD_WIDTH'($urandom);
		end else begin
			c.x = extreme_coord();
			c.y = extreme_coord();
		end
		return c;
	endfunction

	// request driver: prediction happens when a request is put on the port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			waypoint_x <= '0;
			waypoint_y <= '0;
			last_point <= 1'b0;
			cmds_due <= 0;
		end else if (!in_valid || in_ready) begin
			if (wp_q.size() > 0 &&
				$urandom_range(99) >= ((wp_q[0].pace == PACE_SLOW_SINK) ? 25 :
				(wp_q[0].pace == PACE_SLOW_SOURCE) ? 86 : 0) &&
				(!wp_q[0].hold || cmds_seen == cmds_due)) begin
				next_req = wp_q.pop_front();
				cmds_due <= cmds_due + predict_point(next_req.at.x, next_req.at.y,
					next_req.last);
				in_valid <= 1'b1;
				waypoint_x <= next_req.at.x;
				waypoint_y <= next_req.at.y;
				last_point <= next_req.last;
				pace <= next_req.pace;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// command monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			cmds_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				cmds_seen <= cmds_seen + 1;
				if (cmd_due_q.size() == 0) begin
					$error("unexpected command: segment_length %0d turn_angle %0d end_of_path %0b",
						segment_length, turn_angle, end_of_path);
					errs++;
				end else begin
					want = cmd_due_q.pop_front();
					if (segment_length !== want.len) begin
						$error("segment_length: expected %0d, got %0d", want.len, segment_length);
						errs++;
					end
					if (turn_angle !== want.turn) begin
						$error("turn_angle: expected %0d, got %0d", want.turn, turn_angle);
						errs++;
					end
					if (end_of_path !== want.eop) begin
						$error("end_of_path: expected %0b, got %0b", want.eop, end_of_path);
						errs++;
					end
				end
			end
			out_ready <= $urandom_range(99) >= ((pace == PACE_SLOW_SINK) ? 86 :
				(pace == PACE_SLOW_SOURCE) ? 25 : 0);
		end
	end

	// watchdog: cycles without any handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		// lone points
		add_wp(0, 0, 1, 0);
		add_wp(-32768, 32767, 1, 0);
		// two-point path, longest diagonal
		add_wp(-32768, -32768, 0, 0);
		add_wp(32767, 32767, 1, 0);
		// collinear, straight back, zero vectors, both right angles, extremes
		add_wp(0, 0, 0, 0);
		add_wp(16, 0, 0, 0);
		add_wp(32, 0, 0, 0);
		add_wp(16, 0, 0, 0);
		add_wp(16, 0, 0, 0);
		add_wp(16, 16, 0, 0);
		add_wp(0, 16, 0, 0);
		add_wp(0, 32, 0, 0);
		add_wp(32767, -32768, 0, 0);
		add_wp(-32768, 32767, 0, 0);
		add_wp(32767, 32767, 1, 0);
		// short path after a full drain
		add_wp(100, -50, 0, 1);
		add_wp(-3000, 7000, 0, 0);
		add_wp(-1, -1, 1, 0);

		at = '0;
		while (wp_total < 1715) begin
			pick = $urandom_range(99);
			path_len = (pick < 8) ? 1 : (pick < 20) ? 2 : $urandom_range(3, 12);
			for (k = 0; k < path_len; k++) begin
				at = next_coord(at);
				add_wp(at.x, at.y, k == path_len - 1, k == 0 && $urandom_range(99) == 0);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (wp_q.size() != 0 || in_valid || cmds_seen != cmds_due);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errs == 0 && cmd_due_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/wdt_pkg.sv
hw/rtl/wdt_cordic.sv
hw/rtl/waypoints_to_drive_turns_top.sv
tb/tb.sv
